/* hdl/sha256_pkg.sv */
// Package for the SHA-256 stream hasher: round constants, initial hash values
// and the control types shared by the front, queue and core modules.
// Depends on nothing.
package sha256_pkg;

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [7:0] PAD_BYTE    = 8'h80;
    localparam int         BLOCK_BYTES = 64;
    localparam int         LEN_OFFSET  = 56;
    localparam int         BLOCK_BITS  = 512;

    // One queued job for the core: a full 512-bit block, and whether the
    // digest must be emitted (and the chaining words restarted) after it.
    typedef struct packed {
        logic [511:0] block;
        logic         final_blk;
    } job_t;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage

/* hdl/sha256_front.sv */
// Front end: absorbs message bytes into the block buffer, counts length,
// and builds padded blocks on end of message. Depends on sha256_pkg.
module sha256_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [7:0]          s_byte_value,
    input  logic                s_has_byte,
    input  logic                s_end_of_message,
    input  logic                s_valid,
    output logic                s_ready,
    output sha256_pkg::job_t    job,
    output logic                job_valid,
    input  logic                job_ready
);
    import sha256_pkg::*;

    typedef enum logic [2:0] {
        ST_ABSORB = 3'b001,
        ST_PAD2   = 3'b010,
        ST_WAIT   = 3'b100
    } fstate_t;

    fstate_t      state_reg, state_next;
    logic [7:0]   buf_reg [BLOCK_BYTES];
    logic [5:0]   count_reg, count_next;
    logic [63:0]  bits_reg, bits_next;
    logic [63:0]  total;
    logic [5:0]   pend;
    logic [511:0] data_blk, pad_blk, len_blk;
    logic         fill;

    // pending bytes including the byte carried by the word now on offer
    assign pend  = count_reg + {5'd0, state_reg == ST_ABSORB && s_has_byte};
    assign total = bits_reg + {55'd0, pend, 3'd0};

    always_comb begin
        for (int i = 0; i < BLOCK_BYTES; i++) begin
            data_blk[511 - 8*i -: 8] = buf_reg[i];
            if (i == 63 && s_has_byte && count_reg == 6'd63) begin
                data_blk[511 - 8*i -: 8] = s_byte_value;
            end
        end
        // Padded block: pending bytes, 0x80, zeros, length where it fits.
        for (int i = 0; i < BLOCK_BYTES; i++) begin
            if (6'(i) < pend) begin
                if (6'(i) == count_reg) begin
                    pad_blk[511 - 8*i -: 8] = s_byte_value;
                end else begin
                    pad_blk[511 - 8*i -: 8] = buf_reg[i];
                end
            end else if (6'(i) == pend) begin
                pad_blk[511 - 8*i -: 8] = PAD_BYTE;
            end else if (i >= LEN_OFFSET && pend < 6'(LEN_OFFSET)) begin
                pad_blk[511 - 8*i -: 8] = total[63 - 8*(i - LEN_OFFSET) -: 8];
            end else begin
                pad_blk[511 - 8*i -: 8] = 8'd0;
            end
        end
        len_blk = {448'd0, total};
    end

    assign fill = s_has_byte && count_reg == 6'd63;

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        bits_next  = bits_reg;
        s_ready    = 1'b0;
        job_valid  = 1'b0;
        job        = '{block: data_blk, final_blk: 1'b0};
        case (state_reg)
            ST_ABSORB: begin
                if (fill) begin
                    // full block with or without end; end follows in ST_WAIT
                    job_valid = s_valid;
                    s_ready   = job_ready;
                    if (s_valid && job_ready) begin
                        count_next = 6'd0;
                        bits_next  = bits_reg + 64'(BLOCK_BITS);
                        if (s_end_of_message) state_next = ST_WAIT;
                    end
                end else if (s_end_of_message) begin
                    job_valid = s_valid;
                    s_ready   = job_ready;
                    job.block = pad_blk;
                    job.final_blk = pend < 6'(LEN_OFFSET);
                    if (s_valid && job_ready) begin
                        if (pend >= 6'(LEN_OFFSET)) begin
                            count_next = pend;
                            state_next = ST_PAD2;
                        end else begin
                            count_next = 6'd0;
                            bits_next  = 64'd0;
                        end
                    end
                end else begin
                    s_ready = 1'b1;
                    if (s_valid && s_has_byte) count_next = count_reg + 6'd1;
                end
            end
            ST_PAD2: begin
                job_valid = 1'b1;
                job = '{block: len_blk, final_blk: 1'b1};
                if (job_ready) begin
                    state_next = ST_ABSORB;
                    count_next = 6'd0;
                    bits_next  = 64'd0;
                end
            end
            ST_WAIT: begin
                // end of message after a block-filling byte: empty pad block
                job_valid = 1'b1;
                job = '{block: pad_blk, final_blk: 1'b1};
                if (job_ready) begin
                    state_next = ST_ABSORB;
                    bits_next  = 64'd0;
                end
            end
            default: state_next = ST_ABSORB;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_ABSORB;
            count_reg <= 6'd0;
            bits_reg  <= 64'd0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            bits_reg  <= bits_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_ABSORB && s_valid && s_ready && s_has_byte) begin
            buf_reg[count_reg] <= s_byte_value;
        end
    end

    property p_pad2_holds;
        @(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PAD2) |-> job_valid && job.final_blk;
    endproperty
    a_pad2_holds: assert property (p_pad2_holds) else $error("pad2 job");

    property p_no_take_in_pad;
        @(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_ABSORB) |-> !s_ready;
    endproperty
    a_no_take_in_pad: assert property (p_no_take_in_pad) else $error("accept in pad");

    property p_count_clear;
        @(posedge aclk) disable iff (!aresetn)
        (job_valid && job_ready && job.final_blk) |=> count_reg == 6'd0 && bits_reg == 64'd0;
    endproperty
    a_count_clear: assert property (p_count_clear) else $error("restart");

endmodule

/* hdl/sha256_queue.sv */
// Two-entry job queue between front end and core.
// Depends on sha256_pkg.
module sha256_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  sha256_pkg::job_t wr_job,
    input  logic             wr_valid,
    output logic             wr_ready,
    output sha256_pkg::job_t rd_job,
    output logic             rd_valid,
    input  logic             rd_ready
);
    import sha256_pkg::*;

    job_t       mem_reg [2];
    logic       wptr_reg, rptr_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign wr_ready = cnt_reg != 2'd2;
    assign rd_valid = cnt_reg != 2'd0;
    assign rd_job   = mem_reg[rptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end else begin
            if (push) wptr_reg <= ~wptr_reg;
            if (pop)  rptr_reg <= ~rptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wptr_reg] <= wr_job;
    end

    property p_no_over;
        @(posedge aclk) disable iff (!aresetn) cnt_reg != 2'd3;
    endproperty
    a_no_over: assert property (p_no_over) else $error("queue count");

    property p_ptr_match;
        @(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd0 || cnt_reg == 2'd2) |-> wptr_reg == rptr_reg;
    endproperty
    a_ptr_match: assert property (p_ptr_match) else $error("queue pointers");

    property p_full_hold;
        @(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd2 && !pop) |=> cnt_reg == 2'd2;
    endproperty
    a_full_hold: assert property (p_full_hold) else $error("queue full");

endmodule

/* hdl/sha256_core.sv */
// Compression core: one round per cycle with a rolling 16-word schedule,
// then digest output one word at a time, selected by a word index register. Depends on sha256_pkg.
module sha256_core (
    input  logic             aclk,
    input  logic             aresetn,
    input  sha256_pkg::job_t job,
    input  logic             job_valid,
    output logic             job_ready,
    output logic [31:0]      m_digest_word,
    output logic [2:0]       m_word_index,
    output logic             m_last_word,
    output logic             m_valid,
    input  logic             m_ready
);
    import sha256_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_ROUND = 4'b0010,
        ST_ADD   = 4'b0100,
        ST_EMIT  = 4'b1000
    } cstate_t;

    cstate_t     state_reg;
    logic [31:0] h_reg [8];
    logic [31:0] v_reg [8];
    logic [31:0] w_reg [16];
    logic [5:0]  rnd_reg;
    logic        fin_reg;
    logic [2:0]  idx_reg;
    logic [31:0] t1, t2, s0, s1, w_new;

    always_comb begin
        t1 = v_reg[7] + (rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25))
           + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6])) + ROUND_K[rnd_reg] + w_reg[0];
        t2 = (rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22))
           + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
        s0 = rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1 = rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
        w_new = s1 + w_reg[9] + s0 + w_reg[0];
    end

    assign job_ready     = state_reg == ST_IDLE;
    assign m_valid       = state_reg == ST_EMIT;
    assign m_digest_word = h_reg[idx_reg];
    assign m_word_index  = idx_reg;
    assign m_last_word   = idx_reg == 3'd7;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            rnd_reg   <= 6'd0;
            idx_reg   <= 3'd0;
            fin_reg   <= 1'b0;
            for (int i = 0; i < 8; i++) h_reg[i] <= INIT_HASH[i];
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (job_valid) begin
                        for (int i = 0; i < 16; i++) w_reg[i] <= job.block[511 - 32*i -: 32];
                        for (int i = 0; i < 8; i++) v_reg[i] <= h_reg[i];
                        fin_reg   <= job.final_blk;
                        rnd_reg   <= 6'd0;
                        state_reg <= ST_ROUND;
                    end
                end
                ST_ROUND: begin
                    v_reg[0] <= t1 + t2;
                    for (int i = 1; i < 8; i++) begin
                        if (i != 4) v_reg[i] <= v_reg[i-1];
                    end
                    v_reg[4] <= v_reg[3] + t1;
                    for (int i = 0; i < 15; i++) w_reg[i] <= w_reg[i+1];
                    w_reg[15] <= w_new;
                    rnd_reg <= rnd_reg + 6'd1;
                    if (rnd_reg == 6'd63) state_reg <= ST_ADD;
                end
                ST_ADD: begin
                    for (int i = 0; i < 8; i++) h_reg[i] <= h_reg[i] + v_reg[i];
                    idx_reg   <= 3'd0;
                    state_reg <= fin_reg ? ST_EMIT : ST_IDLE;
                end
                ST_EMIT: begin
                    if (m_ready) begin
                        idx_reg <= idx_reg + 3'd1;
                        if (idx_reg == 3'd7) begin
                            for (int i = 0; i < 8; i++) h_reg[i] <= INIT_HASH[i];
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    property p_emit_first;
        @(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> m_word_index == 3'd0;
    endproperty
    a_emit_first: assert property (p_emit_first) else $error("digest order");

    property p_round_end;
        @(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ROUND && rnd_reg == 6'd63) |=> state_reg == ST_ADD;
    endproperty
    a_round_end: assert property (p_round_end) else $error("round count");

    property p_restart;
        @(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last_word) |=> h_reg[0] == INIT_HASH[0];
    endproperty
    a_restart: assert property (p_restart) else $error("hash restart");

endmodule

/* hdl/sha256_stream_hasher.sv */
// SHA-256 stream hasher top level: front end, job queue and compression core.
// Depends on sha256_pkg, sha256_front, sha256_queue, sha256_core.
//
// Takes one word per cycle on the s_ side while s_ready is high, each
// optionally carrying a message byte; a word with s_end_of_message closes
// the message. Ordinary bytes are taken at one per cycle. A word that
// completes a 64-byte block, or that ends the message, hands a block to a
// two-entry queue and stalls while that queue is full. The core compresses
// each block as one load, 64 rounds and one add, so once the queue has
// filled, sustained byte input stalls at each 64-byte block, and longer
// while a digest is held back by m_ready. After the final block the
// digest leaves as eight 32-bit big-endian words on the m_ side, word 0
// first, the eighth marked with m_last_word; the chaining words then return
// to the initial values for the next message.
module sha256_stream_hasher (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [7:0]  s_byte_value,
    input  logic        s_has_byte,
    input  logic        s_end_of_message,
    input  logic        s_valid,
    output logic        s_ready,
    output logic [31:0] m_digest_word,
    output logic [2:0]  m_word_index,
    output logic        m_last_word,
    output logic        m_valid,
    input  logic        m_ready
);
    import sha256_pkg::*;

    job_t fq_job, qc_job;
    logic fq_valid, fq_ready, qc_valid, qc_ready;

    // classify words and build blocks
    sha256_front u_front (
        .aclk, .aresetn, .s_byte_value, .s_has_byte, .s_end_of_message,
        .s_valid, .s_ready,
        .job(fq_job), .job_valid(fq_valid), .job_ready(fq_ready)
    );

    // decouple the byte side from the compression rounds
    sha256_queue u_queue (
        .aclk, .aresetn,
        .wr_job(fq_job), .wr_valid(fq_valid), .wr_ready(fq_ready),
        .rd_job(qc_job), .rd_valid(qc_valid), .rd_ready(qc_ready)
    );

    // compress blocks and emit the digest
    sha256_core u_core (
        .aclk, .aresetn,
        .job(qc_job), .job_valid(qc_valid), .job_ready(qc_ready),
        .m_digest_word, .m_word_index, .m_last_word, .m_valid, .m_ready
    );

endmodule
